// ===== rtl/core/srd_pkg.sv =====
// Shared definitions for the sorted region decoder: sizes, codes and the
// types passed between the sequencer, the compare unit and the top level.
// No dependencies.
package srd_pkg;

  localparam int unsigned REGION_SLOTS      = 32;
  localparam int unsigned LINEAR_SCAN_LIMIT = 5;
  localparam int unsigned ADDR_W            = 32;
  localparam int unsigned IDX_W             = $clog2(REGION_SLOTS);
  localparam int unsigned CNT_W             = $clog2(REGION_SLOTS + 1);
  localparam int unsigned OUT_IDX_W         = 5;
  localparam int unsigned ENTRY_W           = 2 * ADDR_W;
  localparam int unsigned IN_TDATA_W        = 4 * ADDR_W;
  localparam int unsigned OUT_TDATA_W       = 40;

  typedef enum logic [0:0] {
    OP_LOOKUP = 1'b0,
    OP_DEFINE = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PLAN,
    ST_PROBE,
    ST_INS_RD,
    ST_INS_CK,
    ST_RESP
  } state_t;

  typedef enum logic [1:0] {
    PH_RECENT,
    PH_PREV,
    PH_BIN,
    PH_LIN
  } phase_t;

  typedef struct packed {
    logic                 hit;
    logic [OUT_IDX_W-1:0] idx;
    logic [ADDR_W-1:0]    offset;
    logic                 full;
  } res_t;

  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [ENTRY_W-1:0] wdata;
    logic [IDX_W-1:0]   raddr;
  } ram_req_t;

  typedef struct packed {
    logic              key_ge;
    logic              key_gt;
    logic              last_le;
    logic [ADDR_W-1:0] diff;
  } match_t;

endpackage

// ===== rtl/core/srd_ram.sv =====
// Simple dual-port RAM with one write port and one registered read port.
// Holds the region table entries; no dependencies.
module srd_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/srd_match.sv =====
// Shared compare unit: tests one table entry against the search key and the
// last address, and forms the offset from the entry base. Uses srd_pkg.
module srd_match (
  input  logic [srd_pkg::ADDR_W-1:0]  key,
  input  logic [srd_pkg::ADDR_W-1:0]  last_addr,
  input  logic [srd_pkg::ENTRY_W-1:0] entry,
  output srd_pkg::match_t             m
);
  import srd_pkg::*;

  logic [ADDR_W-1:0] base;
  logic [ADDR_W-1:0] limit;

  assign base  = entry[ADDR_W-1:0];
  assign limit = entry[ENTRY_W-1:ADDR_W];

  always_comb begin
    m.key_ge  = key >= base;
    m.key_gt  = key > base;
    m.last_le = last_addr <= limit;
    m.diff    = key - base;
  end

endmodule

// ===== rtl/core/srd_seq.sv =====
// Sequencer of the region decoder: takes one word, walks the region table
// through the RAM read port and the shared compare unit, inserts new regions
// and keeps the recent and previous region indices. Uses srd_pkg and srd_match.
module srd_seq (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_op,
  input  logic [srd_pkg::IN_TDATA_W-1:0] in_data,
  output logic                           res_valid,
  input  logic                           res_ready,
  output srd_pkg::res_t                  res,
  output srd_pkg::ram_req_t              ram_req,
  input  logic [srd_pkg::ENTRY_W-1:0]    ram_rdata
);
  import srd_pkg::*;

  state_t            state_r, state_nxt;
  phase_t            phase_r, phase_nxt;
  logic              op_r, op_nxt;
  logic [ADDR_W-1:0] first_r, first_nxt;
  logic [ADDR_W-1:0] last_r, last_nxt;
  logic [ADDR_W-1:0] nbase_r, nbase_nxt;
  logic [ADDR_W-1:0] nlimit_r, nlimit_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  rec_idx_r, rec_idx_nxt;
  logic              rec_v_r, rec_v_nxt;
  logic [IDX_W-1:0]  prv_idx_r, prv_idx_nxt;
  logic              prv_v_r, prv_v_nxt;
  logic [CNT_W-1:0]  lo_r, lo_nxt;
  logic [CNT_W-1:0]  hi_r, hi_nxt;
  logic [CNT_W-1:0]  lin_r, lin_nxt;
  logic [CNT_W-1:0]  ins_r, ins_nxt;
  logic [IDX_W-1:0]  pa_r, pa_nxt;
  res_t              res_r, res_nxt;

  logic [ADDR_W-1:0] in_first, in_last, in_base, in_limit;
  logic              accept;
  logic              is_full;
  logic              use_bin;
  logic [CNT_W-1:0]  mid;
  logic              plan_go;
  logic              plan_miss;
  logic [IDX_W-1:0]  plan_addr;
  logic [ADDR_W-1:0] key;
  match_t            m;
  logic              holds;

  assign in_first = in_data[ADDR_W-1:0];
  assign in_last  = in_data[2*ADDR_W-1:ADDR_W];
  assign in_base  = in_data[3*ADDR_W-1:2*ADDR_W];
  assign in_limit = in_data[4*ADDR_W-1:3*ADDR_W];

  assign accept  = in_valid && in_ready;
  assign is_full = 32'(count_r) >= REGION_SLOTS;
  assign use_bin = 32'(count_r) >= LINEAR_SCAN_LIMIT;
  assign mid     = lo_r + ((hi_r - lo_r) >> 1);
  assign key     = op_r ? nbase_r : first_r;
  assign holds   = m.key_ge && m.last_le;

  srd_match u_match (
    .key       (key),
    .last_addr (last_r),
    .entry     (ram_rdata),
    .m         (m)
  );

  // Decide whether the current search phase has an entry left to probe.
  always_comb begin
    plan_go   = 1'b0;
    plan_addr = '0;
    case (phase_r)
      PH_RECENT: begin
        plan_go   = rec_v_r && (CNT_W'(rec_idx_r) < count_r);
        plan_addr = rec_idx_r;
      end
      PH_PREV: begin
        plan_go   = prv_v_r && (CNT_W'(prv_idx_r) < count_r);
        plan_addr = prv_idx_r;
      end
      PH_BIN: begin
        plan_go   = hi_r > lo_r;
        plan_addr = mid[IDX_W-1:0];
      end
      PH_LIN: begin
        plan_go   = lin_r < count_r;
        plan_addr = lin_r[IDX_W-1:0];
      end
      default: begin
        plan_go   = 1'b0;
        plan_addr = '0;
      end
    endcase
    plan_miss = (phase_r == PH_LIN) && !plan_go;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_op == OP_DEFINE) begin
            state_nxt = is_full ? ST_RESP : ST_INS_RD;
          end else begin
            state_nxt = (in_first > in_last) ? ST_RESP : ST_PLAN;
          end
        end
      end
      ST_PLAN: begin
        if (plan_go) begin
          state_nxt = ST_PROBE;
        end else if (plan_miss) begin
          state_nxt = ST_RESP;
        end
      end
      ST_PROBE: begin
        state_nxt = holds ? ST_RESP : ST_PLAN;
      end
      ST_INS_RD: begin
        state_nxt = (ins_r == '0) ? ST_RESP : ST_INS_CK;
      end
      ST_INS_CK: begin
        state_nxt = m.key_ge ? ST_RESP : ST_INS_RD;
      end
      ST_RESP: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    phase_nxt   = phase_r;
    op_nxt      = op_r;
    first_nxt   = first_r;
    last_nxt    = last_r;
    nbase_nxt   = nbase_r;
    nlimit_nxt  = nlimit_r;
    count_nxt   = count_r;
    rec_idx_nxt = rec_idx_r;
    rec_v_nxt   = rec_v_r;
    prv_idx_nxt = prv_idx_r;
    prv_v_nxt   = prv_v_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    lin_nxt     = lin_r;
    ins_nxt     = ins_r;
    pa_nxt      = pa_r;
    res_nxt     = res_r;
    in_ready    = 1'b0;
    res_valid   = 1'b0;
    ram_req.we    = 1'b0;
    ram_req.waddr = ins_r[IDX_W-1:0];
    ram_req.wdata = {nlimit_r, nbase_r};
    ram_req.raddr = plan_addr;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          op_nxt     = in_op;
          first_nxt  = in_first;
          last_nxt   = in_last;
          nbase_nxt  = in_base;
          nlimit_nxt = in_limit;
          phase_nxt  = PH_RECENT;
          ins_nxt    = count_r;
          res_nxt    = '0;
          res_nxt.full = (in_op == OP_DEFINE) && is_full;
        end
      end

      ST_PLAN: begin
        if (plan_go) begin
          pa_nxt = plan_addr;
        end else begin
          case (phase_r)
            PH_RECENT: begin
              phase_nxt = PH_PREV;
            end
            PH_PREV: begin
              phase_nxt = use_bin ? PH_BIN : PH_LIN;
              lo_nxt    = '0;
              hi_nxt    = count_r;
              lin_nxt   = '0;
            end
            PH_BIN: begin
              phase_nxt = PH_LIN;
              lin_nxt   = '0;
            end
            default: begin
              res_nxt = '0;
            end
          endcase
        end
      end

      ST_PROBE: begin
        if (holds) begin
          res_nxt.hit    = 1'b1;
          res_nxt.idx    = OUT_IDX_W'(pa_r);
          res_nxt.offset = m.diff;
          res_nxt.full   = 1'b0;
          case (phase_r)
            PH_RECENT: begin
              rec_v_nxt = 1'b1;
            end
            PH_PREV: begin
              rec_idx_nxt = prv_idx_r;
              rec_v_nxt   = 1'b1;
              prv_idx_nxt = rec_idx_r;
              prv_v_nxt   = rec_v_r;
            end
            default: begin
              prv_idx_nxt = rec_idx_r;
              prv_v_nxt   = rec_v_r;
              rec_idx_nxt = pa_r;
              rec_v_nxt   = 1'b1;
            end
          endcase
        end else begin
          case (phase_r)
            PH_RECENT: begin
              phase_nxt = PH_PREV;
            end
            PH_PREV: begin
              phase_nxt = use_bin ? PH_BIN : PH_LIN;
              lo_nxt    = '0;
              hi_nxt    = count_r;
              lin_nxt   = '0;
            end
            PH_BIN: begin
              // The probe address is still the midpoint of lo and hi.
              if (m.key_gt) begin
                lo_nxt = mid + CNT_W'(1);
              end else begin
                hi_nxt = mid;
              end
            end
            default: begin
              lin_nxt = lin_r + CNT_W'(1);
            end
          endcase
        end
      end

      ST_INS_RD: begin
        if (ins_r == '0) begin
          ram_req.we  = 1'b1;
          count_nxt   = count_r + CNT_W'(1);
          if (rec_v_r) begin
            rec_idx_nxt = rec_idx_r + IDX_W'(1);
          end
          if (prv_v_r) begin
            prv_idx_nxt = prv_idx_r + IDX_W'(1);
          end
          res_nxt.hit = 1'b1;
          res_nxt.idx = '0;
        end else begin
          ram_req.raddr = IDX_W'(ins_r - CNT_W'(1));
        end
      end

      ST_INS_CK: begin
        ram_req.we = 1'b1;
        if (!m.key_ge) begin
          // The stored base is above the new one, so that entry moves up a slot.
          ram_req.wdata = ram_rdata;
          ins_nxt       = ins_r - CNT_W'(1);
        end else begin
          count_nxt = count_r + CNT_W'(1);
          if (rec_v_r && (CNT_W'(rec_idx_r) >= ins_r)) begin
            rec_idx_nxt = rec_idx_r + IDX_W'(1);
          end
          if (prv_v_r && (CNT_W'(prv_idx_r) >= ins_r)) begin
            prv_idx_nxt = prv_idx_r + IDX_W'(1);
          end
          res_nxt.hit = 1'b1;
          res_nxt.idx = OUT_IDX_W'(ins_r);
        end
      end

      ST_RESP: begin
        res_valid = 1'b1;
      end

      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  assign res = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      rec_idx_r <= '0;
      rec_v_r   <= 1'b0;
      prv_idx_r <= '0;
      prv_v_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      rec_idx_r <= rec_idx_nxt;
      rec_v_r   <= rec_v_nxt;
      prv_idx_r <= prv_idx_nxt;
      prv_v_r   <= prv_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    phase_r  <= phase_nxt;
    op_r     <= op_nxt;
    first_r  <= first_nxt;
    last_r   <= last_nxt;
    nbase_r  <= nbase_nxt;
    nlimit_r <= nlimit_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    lin_r    <= lin_nxt;
    ins_r    <= ins_nxt;
    pa_r     <= pa_nxt;
    res_r    <= res_nxt;
  end

endmodule

// ===== rtl/core/sorted_region_decoder_with_mru_unit.sv =====
// Top level of the sorted region decoder: sequencer, region RAM and the
// output register. Uses srd_pkg, srd_ram and srd_seq.
//
// The block keeps up to 32 address regions sorted by base and answers one
// word at a time; it is not ready while a word is in progress. Every table
// probe goes through the single registered RAM read port and the shared
// comparator. A lookup probes the most recent region, then the previous one,
// then runs the binary search when the table holds LINEAR_SCAN_LIMIT regions
// or more, and ends with the full linear scan if nothing has hit yet. A
// search phase with no entry to probe is skipped. A reversed range or a full
// table answers without a probe. A define reads the regions from the top
// down, moves every region whose base lies above the new one up a slot and
// then writes the new region, with no compare when it lands in the first
// slot. The result waits in an output register, so the next word is taken
// as soon as the result has moved there.
module sorted_region_decoder_with_mru_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [31:0] first_addr, [63:32] last_addr, [95:64] region_base, [127:96] region_limit
  input  logic [srd_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [0] operation
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] hit, [5:1] region_index, [37:6] offset, [38] table_full, [39] zero
  output logic [srd_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import srd_pkg::*;

  ram_req_t           ram_req;
  logic [ENTRY_W-1:0] ram_rdata;
  logic               res_valid;
  logic               res_ready;
  res_t               res;
  logic               out_valid_r, out_valid_nxt;
  res_t               out_res_r, out_res_nxt;

  srd_ram #(
    .DEPTH (REGION_SLOTS),
    .WIDTH (ENTRY_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  srd_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tuser),
    .in_data   (in_tdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_res_r.full, out_res_r.offset, out_res_r.idx,
                       out_res_r.hit};

endmodule
